>>> src/kws_pkg.sv
// Shared types, codes and constants of the keyframe weight sampler.
package kws_pkg;

   localparam int MAX_KEYS_DEF    = 64;
   localparam int MAX_TARGETS_DEF = 8;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERP_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_COUNT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_DURATION    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TANGENTS_PRESENT = 3'd4;

   localparam logic [1:0] MODE_STEP   = 2'd0;
   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_CUBIC  = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [16:0] ONE_Q16 = 17'd65536;

   localparam logic [3:0] MUL_SS       = 4'd0;
   localparam logic [3:0] MUL_S2S      = 4'd1;
   localparam logic [3:0] MUL_LIN      = 4'd2;
   localparam logic [3:0] MUL_SPAN_TO  = 4'd3;
   localparam logic [3:0] MUL_SPAN_TI  = 4'd4;
   localparam logic [3:0] MUL_H00_WA   = 4'd5;
   localparam logic [3:0] MUL_H01_WB   = 4'd6;
   localparam logic [3:0] MUL_H10_MOLO = 4'd7;
   localparam logic [3:0] MUL_H10_MOHI = 4'd8;
   localparam logic [3:0] MUL_H11_MILO = 4'd9;
   localparam logic [3:0] MUL_H11_MIHI = 4'd10;

   localparam logic [3:0] ACC_NONE   = 4'd0;
   localparam logic [3:0] ACC_S2     = 4'd1;
   localparam logic [3:0] ACC_S3     = 4'd2;
   localparam logic [3:0] ACC_MO     = 4'd3;
   localparam logic [3:0] ACC_MI     = 4'd4;
   localparam logic [3:0] ACC_LOAD   = 4'd5;
   localparam logic [3:0] ACC_ADD    = 4'd6;
   localparam logic [3:0] ACC_ADD_HI = 4'd7;
   localparam logic [3:0] ACC_LIN    = 4'd8;

   typedef struct packed {
      logic               operation;
      logic [5:0]         key_index;
      logic [2:0]         target_index;
      logic [31:0]        key_time;
      logic signed [31:0] key_weight;
      logic signed [31:0] in_tangent;
      logic signed [31:0] out_tangent;
      logic signed [31:0] query_time;
   } kws_req_type;

   typedef struct packed {
      logic [2:0]         result_target;
      logic signed [31:0] sampled_weight;
      logic               last_of_run;
   } kws_rsp_type;

   typedef struct packed {
      logic       idle;
      logic       div_step;
      logic       t_from_rem;
      logic       trd_prev;
      logic       set_next;
      logic       k_inc;
      logic       set_prev;
      logic       div_frac;
      logic       s_fix;
      logic       s_from_q;
      logic       wrd_b;
      logic       cap_a;
      logic       cap_b;
      logic       tgt_inc;
      logic       emit;
      logic [3:0] mul_sel;
      logic [3:0] acc_op;
   } kws_cmd_type;

   typedef struct packed {
      logic req_fire;
      logic is_query;
      logic dur_zero;
      logic div_last;
      logic scan_hit;
      logic frac_div;
      logic cubic;
      logic tgt_last;
      logic out_free;
   } kws_status_type;

endpackage

>>> src/kws_stream_if.sv
// Valid/ready stream channel carrying one payload of type T.
interface kws_stream_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T     data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/keyframe_weight_sampler_core.sv
// Top level of the keyframe weight sampler: sequencer, datapath and checks.
//
// Requests arrive on req_ch (valid/ready). A load request writes one key time and
// one target's weight and tangents into the key tables and
// returns nothing. A query request wraps its time by loop_duration, searches the
// key times for the bracketing pair, computes the blend and returns one response
// per morph target on rsp_ch, in target order, last_of_run set on the final one.
// Configuration is written through csr_we/csr_index/csr_wdata, by the user only while
// idle; the block itself does not enforce this. A query passes through the wrap
// (skipped when the duration is zero), the key scan, the blend division (when
// needed), the blend powers (cubic only) and then per-target step and linear or
// cubic Hermite math. Its timing is set by the bit-serial divider, the linear key
// scan over the single-read-port time table and the one shared 33x33 multiplier.
// A new request is taken only once the previous query has handed its final
// response to the output register. When rsp_ch stalls, the sequencer holds
// the next response and waits. Reset returns the sequencer to idle, drops any
// pending response and restores the register defaults; table contents are
// kept and are undefined until loaded.
module keyframe_weight_sampler_core #(
   parameter int MAX_KEYS    = kws_pkg::MAX_KEYS_DEF,
   parameter int MAX_TARGETS = kws_pkg::MAX_TARGETS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   kws_stream_if.sink                     req_ch,
   kws_stream_if.source                   rsp_ch,
   input  logic                           csr_we,
   input  logic [kws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kws_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import kws_pkg::*;

   kws_cmd_type    cmd;
   kws_status_type stat;

   kws_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   kws_dp #(
      .MAX_KEYS    (MAX_KEYS),
      .MAX_TARGETS (MAX_TARGETS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.data.operation == OP_LOAD) &&
       !rsp_ch.valid) |=> !rsp_ch.valid)
      else $error("load request produced a response");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.data.operation == OP_QUERY))
      |=> !req_ch.ready)
      else $error("request taken while a query is in progress");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("response overwritten before it was taken");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !req_ch.ready)
      else $error("response emitted while idle");
endmodule

>>> src/kws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> src/kws_ctrl.sv
// Sequencer of the sampler: walks a query through wrap, search, blend and per-target math.
module kws_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  kws_pkg::kws_status_type stat,
   output kws_pkg::kws_cmd_type    cmd
);
   import kws_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_MOD    = 5'd1;
   localparam logic [4:0] S_MODEND = 5'd2;
   localparam logic [4:0] S_SRD    = 5'd3;
   localparam logic [4:0] S_SCMP   = 5'd4;
   localparam logic [4:0] S_PRD    = 5'd5;
   localparam logic [4:0] S_PCAP   = 5'd6;
   localparam logic [4:0] S_BLEND  = 5'd7;
   localparam logic [4:0] S_FRAC   = 5'd8;
   localparam logic [4:0] S_FEND   = 5'd9;
   localparam logic [4:0] S_SQ     = 5'd10;
   localparam logic [4:0] S_S2     = 5'd11;
   localparam logic [4:0] S_S3I    = 5'd12;
   localparam logic [4:0] S_S3     = 5'd13;
   localparam logic [4:0] S_T0     = 5'd14;
   localparam logic [4:0] S_T1     = 5'd15;
   localparam logic [4:0] S_T2     = 5'd16;
   localparam logic [4:0] S_L0     = 5'd17;
   localparam logic [4:0] S_L1     = 5'd18;
   localparam logic [4:0] S_C0     = 5'd19;
   localparam logic [4:0] S_C1     = 5'd20;
   localparam logic [4:0] S_C2     = 5'd21;
   localparam logic [4:0] S_C3     = 5'd22;
   localparam logic [4:0] S_C4     = 5'd23;
   localparam logic [4:0] S_C5     = 5'd24;
   localparam logic [4:0] S_C6     = 5'd25;
   localparam logic [4:0] S_C7     = 5'd26;
   localparam logic [4:0] S_C8     = 5'd27;
   localparam logic [4:0] S_OUT    = 5'd28;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_SS;
      cmd.acc_op  = ACC_NONE;
      state_in    = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (stat.req_fire && stat.is_query) begin
               state_in = stat.dur_zero ? S_SRD : S_MOD;
            end
         end
         S_MOD: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_MODEND;
            end
         end
         S_MODEND: begin
            cmd.t_from_rem = 1'b1;
            state_in       = S_SRD;
         end
         S_SRD: begin
            state_in = S_SCMP;
         end
         S_SCMP: begin
            if (stat.scan_hit) begin
               cmd.set_next = 1'b1;
               state_in     = S_PRD;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = S_SRD;
            end
         end
         S_PRD: begin
            cmd.trd_prev = 1'b1;
            state_in     = S_PCAP;
         end
         S_PCAP: begin
            cmd.set_prev = 1'b1;
            state_in     = S_BLEND;
         end
         S_BLEND: begin
            if (stat.frac_div) begin
               cmd.div_frac = 1'b1;
               state_in     = S_FRAC;
            end else begin
               cmd.s_fix = 1'b1;
               state_in  = S_SQ;
            end
         end
         S_FRAC: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_FEND;
            end
         end
         S_FEND: begin
            cmd.s_from_q = 1'b1;
            state_in     = S_SQ;
         end
         S_SQ: begin
            cmd.mul_sel = MUL_SS;
            state_in    = stat.cubic ? S_S2 : S_T0;
         end
         S_S2: begin
            cmd.acc_op = ACC_S2;
            state_in   = S_S3I;
         end
         S_S3I: begin
            cmd.mul_sel = MUL_S2S;
            state_in    = S_S3;
         end
         S_S3: begin
            cmd.acc_op = ACC_S3;
            state_in   = S_T0;
         end
         S_T0: begin
            state_in = S_T1;
         end
         S_T1: begin
            cmd.cap_a = 1'b1;
            cmd.wrd_b = 1'b1;
            state_in  = S_T2;
         end
         S_T2: begin
            cmd.cap_b = 1'b1;
            state_in  = stat.cubic ? S_C0 : S_L0;
         end
         S_L0: begin
            cmd.mul_sel = MUL_LIN;
            state_in    = S_L1;
         end
         S_L1: begin
            cmd.acc_op = ACC_LIN;
            state_in   = S_OUT;
         end
         S_C0: begin
            cmd.mul_sel = MUL_SPAN_TO;
            state_in    = S_C1;
         end
         S_C1: begin
            cmd.acc_op  = ACC_MO;
            cmd.mul_sel = MUL_SPAN_TI;
            state_in    = S_C2;
         end
         S_C2: begin
            cmd.acc_op  = ACC_MI;
            cmd.mul_sel = MUL_H00_WA;
            state_in    = S_C3;
         end
         S_C3: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_H01_WB;
            state_in    = S_C4;
         end
         S_C4: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_sel = MUL_H10_MOLO;
            state_in    = S_C5;
         end
         S_C5: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_sel = MUL_H10_MOHI;
            state_in    = S_C6;
         end
         S_C6: begin
            cmd.acc_op  = ACC_ADD_HI;
            cmd.mul_sel = MUL_H11_MILO;
            state_in    = S_C7;
         end
         S_C7: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_sel = MUL_H11_MIHI;
            state_in    = S_C8;
         end
         S_C8: begin
            cmd.acc_op = ACC_ADD_HI;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.tgt_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.tgt_inc = 1'b1;
                  state_in    = S_T0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

>>> src/kws_dp.sv
// Datapath of the sampler: registers, key tables, divider, multiplier and output stage.
module kws_dp #(
   parameter int MAX_KEYS    = kws_pkg::MAX_KEYS_DEF,
   parameter int MAX_TARGETS = kws_pkg::MAX_TARGETS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   kws_stream_if.sink                      req_ch,
   kws_stream_if.source                    rsp_ch,
   input  logic                            csr_we,
   input  logic [kws_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kws_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  kws_pkg::kws_cmd_type            cmd,
   output kws_pkg::kws_status_type         stat
);
   import kws_pkg::*;

   localparam int KIDX_W  = $clog2(MAX_KEYS);
   localparam int TIDX_W  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int ENTRIES = MAX_KEYS * MAX_TARGETS;
   localparam int EADDR_W = $clog2(ENTRIES);

   // configuration registers
   logic [1:0]  mode_ff;
   logic [3:0]  tcount_ff;
   logic [6:0]  kcount_ff;
   logic [31:0] dur_ff;
   logic        tan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_LINEAR;
         tcount_ff <= 4'd1;
         kcount_ff <= 7'd1;
         dur_ff    <= '0;
         tan_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INTERP_MODE:      mode_ff   <= csr_wdata[1:0];
            CSR_TARGET_COUNT:     tcount_ff <= csr_wdata[3:0];
            CSR_KEY_COUNT:        kcount_ff <= csr_wdata[6:0];
            CSR_LOOP_DURATION:    dur_ff    <= csr_wdata;
            CSR_TANGENTS_PRESENT: tan_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective counts
   logic [31:0]       n_cnt;
   logic [31:0]       tc_cnt;
   logic [KIDX_W-1:0] n_last;
   logic [TIDX_W-1:0] tc_last;

   always_comb begin
      if (kcount_ff == 7'd0) begin
         n_cnt = 32'd1;
      end else if (32'(kcount_ff) > 32'(MAX_KEYS)) begin
         n_cnt = 32'(MAX_KEYS);
      end else begin
         n_cnt = 32'(kcount_ff);
      end
      if (tcount_ff == 4'd0) begin
         tc_cnt = 32'd1;
      end else if (32'(tcount_ff) > 32'(MAX_TARGETS)) begin
         tc_cnt = 32'(MAX_TARGETS);
      end else begin
         tc_cnt = 32'(tcount_ff);
      end
   end

   assign n_last  = KIDX_W'(n_cnt - 32'd1);
   assign tc_last = TIDX_W'(tc_cnt - 32'd1);

   // request side
   logic               req_fire;
   logic               in_range;
   logic               wr_en;
   logic [KIDX_W-1:0]  wr_key;
   logic [EADDR_W-1:0] wr_ent;
   logic [31:0]        t0;

   assign req_ch.ready = cmd.idle;
   assign req_fire     = req_ch.valid && cmd.idle;
   assign in_range     = (32'(req_ch.data.key_index) < 32'(MAX_KEYS)) &&
                         (32'(req_ch.data.target_index) < 32'(MAX_TARGETS));
   assign wr_en        = req_fire && (req_ch.data.operation == OP_LOAD) && in_range;
   assign wr_key       = KIDX_W'(req_ch.data.key_index);
   assign wr_ent       = EADDR_W'(wr_key) * EADDR_W'(MAX_TARGETS) +
                         EADDR_W'(req_ch.data.target_index);
   assign t0           = req_ch.data.query_time[31] ? 32'd0 : req_ch.data.query_time;

   // search and blend state
   logic [31:0]        t_ff;
   logic [KIDX_W-1:0]  k_ff;
   logic [KIDX_W-1:0]  next_ff;
   logic [KIDX_W-1:0]  prev;
   logic [31:0]        tn_ff;
   logic [31:0]        tp_ff;
   logic [TIDX_W-1:0]  tgt_ff;
   logic [16:0]        s_ff;
   logic [16:0]        s2_ff;
   logic [16:0]        s3_ff;
   logic               same;
   logic signed [32:0] span;
   logic signed [32:0] num;
   logic               active;

   // divider
   logic [31:0] rem_ff;
   logic [31:0] dvd_ff;
   logic [31:0] dd_ff;
   logic [5:0]  dcnt_ff;
   logic [15:0] q_ff;
   logic [32:0] trial;
   logic        ge;

   // tables
   logic [31:0]        rd_time;
   logic [31:0]        w_rd;
   logic [31:0]        it_rd;
   logic [31:0]        ot_rd;
   logic [KIDX_W-1:0]  trd_addr;
   logic [EADDR_W-1:0] addr_a;
   logic [EADDR_W-1:0] addr_b;

   // arithmetic
   logic signed [31:0] wa_ff;
   logic signed [31:0] wb_ff;
   logic signed [31:0] to_ff;
   logic signed [31:0] ti_ff;
   logic signed [48:0] mo_ff;
   logic signed [48:0] mi_ff;
   logic signed [65:0] p_ff;
   logic signed [67:0] acc_ff;
   logic signed [19:0] sx;
   logic signed [19:0] s2x;
   logic signed [19:0] s3x;
   logic signed [19:0] h00;
   logic signed [19:0] h10;
   logic signed [19:0] h01;
   logic signed [19:0] h11;
   logic signed [32:0] ma;
   logic signed [32:0] mb;
   logic signed [67:0] p_ext;

   // output stage
   logic        rsp_valid_ff;
   kws_rsp_type rsp_data_ff;
   logic [31:0] w_sat;

   assign prev   = (next_ff == '0) ? '0 : next_ff - KIDX_W'(1);
   assign same   = (next_ff == '0);
   assign span   = $signed({1'b0, tn_ff}) - $signed({1'b0, tp_ff});
   assign num    = $signed({1'b0, t_ff}) - $signed({1'b0, tp_ff});
   assign active = (mode_ff != MODE_STEP) && !same && (span > 33'sd0);

   assign trial = {rem_ff, dvd_ff[31]};
   assign ge    = trial >= {1'b0, dd_ff};

   assign trd_addr = cmd.trd_prev ? prev : k_ff;
   assign addr_a   = EADDR_W'(prev) * EADDR_W'(MAX_TARGETS) + EADDR_W'(tgt_ff);
   assign addr_b   = EADDR_W'(next_ff) * EADDR_W'(MAX_TARGETS) + EADDR_W'(tgt_ff);

   kws_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_times (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_key),
      .wdata (req_ch.data.key_time),
      .raddr (trd_addr),
      .rdata (rd_time)
   );

   kws_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_weights (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_ent),
      .wdata (req_ch.data.key_weight),
      .raddr (cmd.wrd_b ? addr_b : addr_a),
      .rdata (w_rd)
   );

   kws_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_in_tan (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_ent),
      .wdata (req_ch.data.in_tangent),
      .raddr (addr_b),
      .rdata (it_rd)
   );

   kws_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_out_tan (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_ent),
      .wdata (req_ch.data.out_tangent),
      .raddr (addr_a),
      .rdata (ot_rd)
   );

   // Hermite basis from the registered blend powers
   assign sx  = $signed({3'b000, s_ff});
   assign s2x = $signed({3'b000, s2_ff});
   assign s3x = $signed({3'b000, s3_ff});
   assign h00 = (s3x <<< 1) - (s2x + (s2x <<< 1)) + 20'sd65536;
   assign h10 = s3x - (s2x <<< 1) + sx;
   assign h01 = (s2x + (s2x <<< 1)) - (s3x <<< 1);
   assign h11 = s3x - s2x;

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_SS: begin
            ma = $signed({16'd0, s_ff});
            mb = $signed({16'd0, s_ff});
         end
         MUL_S2S: begin
            ma = $signed({16'd0, s2_ff});
            mb = $signed({16'd0, s_ff});
         end
         MUL_LIN: begin
            ma = $signed({wb_ff[31], wb_ff}) - $signed({wa_ff[31], wa_ff});
            mb = $signed({16'd0, s_ff});
         end
         MUL_SPAN_TO: begin
            ma = span;
            mb = $signed({to_ff[31], to_ff});
         end
         MUL_SPAN_TI: begin
            ma = span;
            mb = $signed({ti_ff[31], ti_ff});
         end
         MUL_H00_WA: begin
            ma = $signed({{13{h00[19]}}, h00});
            mb = $signed({wa_ff[31], wa_ff});
         end
         MUL_H01_WB: begin
            ma = $signed({{13{h01[19]}}, h01});
            mb = $signed({wb_ff[31], wb_ff});
         end
         MUL_H10_MOLO: begin
            ma = $signed({{13{h10[19]}}, h10});
            mb = $signed({1'b0, mo_ff[31:0]});
         end
         MUL_H10_MOHI: begin
            ma = $signed({{13{h10[19]}}, h10});
            mb = $signed({{16{mo_ff[48]}}, mo_ff[48:32]});
         end
         MUL_H11_MILO: begin
            ma = $signed({{13{h11[19]}}, h11});
            mb = $signed({1'b0, mi_ff[31:0]});
         end
         MUL_H11_MIHI: begin
            ma = $signed({{13{h11[19]}}, h11});
            mb = $signed({{16{mi_ff[48]}}, mi_ff[48:32]});
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   assign p_ext = $signed({{2{p_ff[65]}}, p_ff});

   always_ff @(posedge clock) begin
      p_ff <= ma * mb;

      if (req_fire && (req_ch.data.operation == OP_QUERY)) begin
         t_ff    <= '0;
         k_ff    <= '0;
         tgt_ff  <= '0;
         rem_ff  <= '0;
         dvd_ff  <= t0;
         dd_ff   <= dur_ff;
         dcnt_ff <= 6'd32;
      end

      if (cmd.div_step) begin
         rem_ff  <= ge ? 32'(trial - {1'b0, dd_ff}) : trial[31:0];
         dvd_ff  <= {dvd_ff[30:0], 1'b0};
         q_ff    <= {q_ff[14:0], ge};
         dcnt_ff <= dcnt_ff - 6'd1;
      end
      if (cmd.div_frac) begin
         rem_ff  <= num[31:0];
         dvd_ff  <= '0;
         dd_ff   <= span[31:0];
         dcnt_ff <= 6'd16;
      end
      if (cmd.t_from_rem) begin
         t_ff <= rem_ff;
      end

      if (cmd.k_inc) begin
         k_ff <= k_ff + KIDX_W'(1);
      end
      if (cmd.set_next) begin
         next_ff <= k_ff;
         tn_ff   <= rd_time;
      end
      if (cmd.set_prev) begin
         tp_ff <= rd_time;
      end

      if (cmd.s_fix) begin
         s_ff <= (active && (num >= span)) ? ONE_Q16 : 17'd0;
      end
      if (cmd.s_from_q) begin
         s_ff <= {1'b0, q_ff};
      end

      if (cmd.cap_a) begin
         wa_ff <= w_rd;
         to_ff <= ot_rd;
         ti_ff <= it_rd;
      end
      if (cmd.cap_b) begin
         wb_ff <= w_rd;
      end
      if (cmd.tgt_inc) begin
         tgt_ff <= tgt_ff + TIDX_W'(1);
      end

      unique case (cmd.acc_op)
         ACC_S2:     s2_ff  <= p_ff[32:16];
         ACC_S3:     s3_ff  <= p_ff[32:16];
         ACC_MO:     mo_ff  <= p_ff[64:16];
         ACC_MI:     mi_ff  <= p_ff[64:16];
         ACC_LOAD:   acc_ff <= p_ext;
         ACC_ADD:    acc_ff <= acc_ff + p_ext;
         ACC_ADD_HI: acc_ff <= acc_ff + (p_ext <<< 32);
         ACC_LIN:    acc_ff <= $signed({{20{wa_ff[31]}}, wa_ff, 16'd0}) + p_ext;
         default: ;
      endcase
   end

   // saturate floor(acc / 2^16) to 32 bits
   always_comb begin
      if (!acc_ff[67] && (acc_ff[66:47] != '0)) begin
         w_sat = 32'h7FFF_FFFF;
      end else if (acc_ff[67] && (acc_ff[66:47] != '1)) begin
         w_sat = 32'h8000_0000;
      end else begin
         w_sat = acc_ff[47:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.result_target  <= 3'(tgt_ff);
         rsp_data_ff.sampled_weight <= w_sat;
         rsp_data_ff.last_of_run    <= (tgt_ff == tc_last);
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   assign stat.req_fire = req_fire;
   assign stat.is_query = (req_ch.data.operation == OP_QUERY);
   assign stat.dur_zero = (dur_ff == '0);
   assign stat.div_last = (dcnt_ff == 6'd1);
   assign stat.scan_hit = (rd_time > t_ff) || (k_ff == n_last);
   assign stat.frac_div = active && (num > 33'sd0) && (num < span);
   assign stat.cubic    = (mode_ff == MODE_CUBIC) && tan_ff && !same;
   assign stat.tgt_last = (tgt_ff == tc_last);
   assign stat.out_free = !rsp_valid_ff || rsp_ch.ready;
endmodule

>>> dv/keyframe_weight_sampler_core_test.sv
// Testbench for the keyframe weight sampler: directed and random loads and queries, scoreboarded.
`timescale 1ns / 1ps

class kws_weight_board;
   kws_pkg::kws_rsp_type pending_weights[$];
   int errors;
   int checked;

   logic [1:0]  mode;
   logic [3:0]  tcount;
   logic [6:0]  kcount;
   logic [31:0] duration;
   logic        tangents;
   logic [31:0]        times[64];
   logic signed [31:0] weights[512];
   logic signed [31:0] tin[512];
   logic signed [31:0] tout[512];

   function new();
      mode = kws_pkg::MODE_LINEAR;
      tcount = 1;
      kcount = 1;
      duration = 0;
      tangents = 0;
      errors = 0;
      checked = 0;
      foreach (times[i]) times[i] = 0;
      foreach (weights[i]) begin
         weights[i] = 0;
         tin[i] = 0;
         tout[i] = 0;
      end
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
         kws_pkg::CSR_INTERP_MODE: mode = val[1:0];
         kws_pkg::CSR_TARGET_COUNT: tcount = val[3:0];
         kws_pkg::CSR_KEY_COUNT: kcount = val[6:0];
         kws_pkg::CSR_LOOP_DURATION: duration = val;
         kws_pkg::CSR_TANGENTS_PRESENT: tangents = val[0];
         default: ;
      endcase
   endfunction

   function longint fl16(longint v);
      return v >>> 16;
   endfunction

   function void note_request(kws_pkg::kws_req_type r);
      int n, tc, nx, pv, e, a, b;
      longint t, span, num, s, s2, s3, h00, h10, h01, h11, wa, wb, w, mo, mi;
      bit cubic;
      kws_pkg::kws_rsp_type x;
      if (r.operation == kws_pkg::OP_LOAD) begin
         e = r.key_index * 8 + r.target_index;
         times[r.key_index] = r.key_time;
         weights[e] = r.key_weight;
         tin[e] = r.in_tangent;
         tout[e] = r.out_tangent;
         return;
      end
      n = (kcount == 0) ? 1 : (kcount > 64 ? 64 : kcount);
      tc = (tcount == 0) ? 1 : (tcount > 8 ? 8 : tcount);
      t = (r.query_time < 0) ? 0 : longint'(r.query_time);
      t = (duration == 0) ? 0 : t % longint'(duration);
      nx = n - 1;
      for (int k = 0; k < n; k++)
         if (longint'(times[k]) > t) begin
            nx = k;
            break;
         end
      pv = (nx == 0) ? 0 : nx - 1;
      s = 0;
      span = 0;
      if (nx != pv) span = longint'(times[nx]) - longint'(times[pv]);
      if (mode != kws_pkg::MODE_STEP && nx != pv && span > 0) begin
         num = t - longint'(times[pv]);
         if (num <= 0) s = 0;
         else if (num >= span) s = 65536;
         else s = (num << 16) / span;
      end
      cubic = (mode == kws_pkg::MODE_CUBIC) && tangents && nx != pv;
      s2 = (s * s) >>> 16;
      s3 = (s2 * s) >>> 16;
      h00 = 2 * s3 - 3 * s2 + 65536;
      h10 = s3 - 2 * s2 + s;
      h01 = 3 * s2 - 2 * s3;
      h11 = s3 - s2;
      for (int k = 0; k < tc; k++) begin
         a = pv * 8 + k;
         b = nx * 8 + k;
         wa = weights[a];
         wb = weights[b];
         if (cubic) begin
            mo = fl16(span * longint'(tout[a]));
            mi = fl16(span * longint'(tin[b]));
            w = fl16(h00 * wa + h10 * mo + h01 * wb + h11 * mi);
         end else begin
            w = wa + fl16((wb - wa) * s);
         end
         if (w > 64'sd2147483647) w = 64'sd2147483647;
         if (w < -64'sd2147483648) w = -64'sd2147483648;
         x.result_target = k[2:0];
         x.sampled_weight = w[31:0];
         x.last_of_run = (k == tc - 1);
         pending_weights.push_back(x);
      end
   endfunction

   function void check_weight(kws_pkg::kws_rsp_type got);
      kws_pkg::kws_rsp_type want;
      checked++;
      if (pending_weights.size() == 0) begin
         $display("%0t unexpected response: expected none, actual %h", $time, got);
         errors++;
         return;
      end
      want = pending_weights.pop_front();
      if (got.result_target !== want.result_target) begin
         $display("%0t result_target expected %0d actual %0d", $time,
                  want.result_target, got.result_target);
         errors++;
      end
      if (got.sampled_weight !== want.sampled_weight) begin
         $display("%0t sampled_weight expected %h actual %h", $time,
                  want.sampled_weight, got.sampled_weight);
         errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
         $display("%0t last_of_run expected %b actual %b", $time,
                  want.last_of_run, got.last_of_run);
         errors++;
      end
   endfunction
endclass

module keyframe_weight_sampler_core_test;
   import kws_pkg::*;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   kws_stream_if #(.T(kws_req_type)) req_ch ();
   kws_stream_if #(.T(kws_rsp_type)) rsp_ch ();

   keyframe_weight_sampler_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   kws_weight_board board = new();
   kws_req_type request_queue[$];
   int hold_off;
   int idle_cycles;
   int queries;
   int loads;
   bit stim_done;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
      hold_off = 0;
      stim_done = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
   end

   // receiver: own stall pattern, plus a long hold-off on request
   initial begin
      int phase;
      int pat;
      phase = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) board.check_weight(rsp_ch.data);
         phase++;
         if (phase % 400 == 0) pat = $urandom_range(0, 3);
         if (hold_off > 0) begin
            hold_off--;
            rsp_ch.ready <= 0;
         end else case (pat)
            0: rsp_ch.ready <= 1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= (phase % 5 < 2);
            default: rsp_ch.ready <= $urandom_range(0, 1);
         endcase
      end
   end

   // watchdog
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 20000) begin
            $display("timeout");
            $display("keyframe_weight_sampler_core_test NOT OK");
            $finish;
         end
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      board.write_reg(idx, val);
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic send_requests();
      int burst;
      while (request_queue.size() > 0) begin
         burst = $urandom_range(1, 8);
         while (burst > 0 && request_queue.size() > 0) begin
            req_ch.valid <= 1;
            req_ch.data <= request_queue[0];
            @(posedge clock);
            while (!req_ch.ready) @(posedge clock);
            board.note_request(request_queue.pop_front());
            burst--;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      req_ch.valid <= 0;
   endtask

   task automatic drain();
      while (board.pending_weights.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic kws_req_type load_req(int k, int tg, logic [31:0] kt,
                                            logic [31:0] w, logic [31:0] ti,
                                            logic [31:0] to);
      kws_req_type r;
      r = '0;
      r.operation = OP_LOAD;
      r.key_index = 6'(k);
      r.target_index = 3'(tg);
      r.key_time = kt;
      r.key_weight = w;
      r.in_tangent = ti;
      r.out_tangent = to;
      r.query_time = $urandom;
      loads++;
      return r;
   endfunction

   function automatic kws_req_type query_req(logic [31:0] qt);
      kws_req_type r;
      r = '0;
      r.operation = OP_QUERY;
      r.query_time = qt;
      r.key_index = 6'($urandom);
      r.target_index = 3'($urandom);
      r.key_time = $urandom;
      r.key_weight = $urandom;
      r.in_tangent = $urandom;
      r.out_tangent = $urandom;
      queries++;
      return r;
   endfunction

   // fill keys 0..nk-1 and targets 0..nt-1 with non-decreasing times
   task automatic load_table(int nk, int nt, int stepmax, bit wide);
      logic [31:0] kt;
      kt = wide ? 32'h0 : $urandom_range(0, 100);
      for (int k = 0; k < nk; k++) begin
         for (int tg = 0; tg < nt; tg++)
            request_queue.push_back(load_req(k, tg, kt,
               wide ? $urandom : $urandom_range(0, 32'h40000) - 32'h20000,
               wide ? $urandom : $urandom_range(0, 32'h80000) - 32'h40000,
               wide ? $urandom : $urandom_range(0, 32'h80000) - 32'h40000));
         if (k == nk - 2 && wide) kt = 32'hFFFFFFFF;
         else kt = kt + $urandom_range(0, stepmax);
      end
      send_requests();
   endtask

   initial begin
      logic [31:0] dur;
      int nk, nt;
      queries = 0;
      loads = 0;
      @(negedge reset);
      @(posedge clock);

      // directed: long key scan over the whole table, oversized key count
      load_table(64, 1, 32'h3000000, 0);
      write_csr(CSR_KEY_COUNT, 127);
      write_csr(CSR_LOOP_DURATION, 32'hFFFFFFFF);
      request_queue.push_back(query_req(32'h7FFFFFFF));
      request_queue.push_back(query_req(32'h40000000));
      request_queue.push_back(query_req($urandom));
      send_requests();
      drain();

      // directed: extremes, every mode, special cases
      load_table(4, 8, 32'h30000, 1);
      write_csr(CSR_KEY_COUNT, 4);
      write_csr(CSR_TARGET_COUNT, 8);
      write_csr(CSR_TANGENTS_PRESENT, 1);
      for (int m = 0; m < 4; m++) begin
         write_csr(CSR_INTERP_MODE, m);
         if (m == MODE_CUBIC) hold_off = 300;
         request_queue.push_back(query_req(32'h80000000));
         request_queue.push_back(query_req(32'h7FFFFFFF));
         request_queue.push_back(query_req(32'h0));
         request_queue.push_back(query_req($urandom));
         send_requests();
         drain();
      end
      write_csr(CSR_TANGENTS_PRESENT, 0);
      write_csr(CSR_LOOP_DURATION, 0);
      write_csr(CSR_TARGET_COUNT, 0);
      write_csr(CSR_KEY_COUNT, 0);
      request_queue.push_back(query_req($urandom));
      request_queue.push_back(load_req(7, 7, 32'h10, 32'h7FFFFFFF, 32'h80000000, 32'h1));
      send_requests();
      drain();
      write_csr(CSR_TARGET_COUNT, 15);
      write_csr(CSR_KEY_COUNT, 127);
      write_csr(CSR_INTERP_MODE, MODE_CUBIC);
      write_csr(CSR_TANGENTS_PRESENT, 1);
      write_csr(CSR_LOOP_DURATION, 32'h00010000);
      request_queue.push_back(query_req(32'h1234));
      send_requests();
      drain();
      // decreasing key time, then query
      request_queue.push_back(load_req(3, 0, 32'h5, 32'h10000, 0, 0));
      request_queue.push_back(query_req(32'hFFFFFFFF));
      send_requests();
      drain();

      // random phases
      while (queries + loads < 180) begin
         nk = $urandom_range(1, 4);
         nt = $urandom_range(1, 8);
         if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 3) == 0) load_table(nk, nt, 32'h7FFFF, 1);
            else load_table(nk, nt, 32'h8000, 0);
         end
         write_csr(CSR_INTERP_MODE, $urandom_range(0, 3));
         write_csr(CSR_TARGET_COUNT, nt);
         write_csr(CSR_KEY_COUNT, nk);
         write_csr(CSR_TANGENTS_PRESENT, $urandom_range(0, 1));
         dur = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, nk * 32'h8000);
         write_csr(CSR_LOOP_DURATION, dur);
         if ($urandom_range(0, 3) == 0) hold_off = 300;
         repeat ($urandom_range(6, 14)) begin
            if ($urandom_range(0, 7) == 0)
               request_queue.push_back(load_req($urandom_range(0, nk - 1),
                  $urandom_range(0, nt - 1), $urandom_range(0, 32'h8000 * nk),
                  $urandom, $urandom, $urandom));
            else
               request_queue.push_back(query_req(($urandom_range(0, 5) == 0) ?
                  $urandom : $urandom_range(0, 32'h8000 * nk)));
         end
         send_requests();
         drain();
      end

      $display("covered %0d queries and %0d loads over all modes and counts", queries, loads);
      $display("checked %0d responses", board.checked);
      if (board.errors == 0 && board.pending_weights.size() == 0) begin
         $display("keyframe_weight_sampler_core_test OK");
      end else begin
         $display("keyframe_weight_sampler_core_test NOT OK");
      end
      $finish;
   end
endmodule
